### rtl/core/tfp_pkg.sv
package tfp_pkg;

  localparam logic [7:0] SYNC_RESET  = 8'h16;
  localparam int         PAYLOAD_LEN = 9;

  localparam logic [7:0] HDR_ENCODER = 8'd2;
  localparam logic [7:0] HDR_OBJECT  = 8'd4;

  localparam logic [7:0] COL_GREEN = 8'd0;
  localparam logic [7:0] COL_RED   = 8'd1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ENCODER = 2'd0,
    KIND_BATTERY = 2'd1,
    KIND_OBJECT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ENCODER = 2'd1,
    EV_BATTERY = 2'd2,
    EV_OBJECT  = 2'd3
  } event_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic [31:0]        encoder_sum;
    logic [15:0]        battery_raw;
    logic               green_seen;
    logic signed [31:0] green_x;
    logic signed [31:0] green_y;
    logic               red_seen;
    logic signed [31:0] red_x;
    logic signed [31:0] red_y;
  } out_t;

  function automatic logic [3:0] frame_len(kind_t kind);
    logic [3:0] len;
    case (kind)
      KIND_ENCODER: len = 4'd1;
      KIND_BATTERY: len = 4'd2;
      default:      len = 4'(PAYLOAD_LEN);
    endcase
    return len;
  endfunction

endpackage

### rtl/core/tfp_parser.sv
module tfp_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    sync_byte,
  input  logic          item_vld,
  input  tfp_pkg::in_t  item,
  output tfp_pkg::out_t res
);
  import tfp_pkg::*;

  phase_t             phase_r, phase_nxt;
  kind_t              kind_r, kind_nxt;
  logic [3:0]         idx_r, idx_nxt;
  logic [3:0]         idx_inc;
  logic               last_byte;
  logic [7:0]         payload_r [PAYLOAD_LEN];
  logic [7:0]         payload_nxt [PAYLOAD_LEN];
  logic [31:0]        acc_r, acc_nxt;
  logic [15:0]        batt_r, batt_nxt;
  logic [1:0]         vis_r, vis_nxt;
  logic signed [31:0] x_r [2];
  logic signed [31:0] x_nxt [2];
  logic signed [31:0] y_r [2];
  logic signed [31:0] y_nxt [2];
  logic signed [31:0] obj_x, obj_y;
  logic               obj_vis;
  event_t             ev;
  logic [31:0]        sum;

  assign idx_inc   = idx_r + 4'd1;
  assign last_byte = (idx_inc >= frame_len(kind_r));

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (item.op == OP_BYTE) begin
      case (phase_r)
        PH_HUNT: begin
          if (item.rx_byte == sync_byte) phase_nxt = PH_HEADER;
        end
        PH_HEADER: begin
          if (item.rx_byte inside {[HDR_ENCODER:HDR_OBJECT]}) phase_nxt = PH_PAYLOAD;
          else phase_nxt = PH_HUNT;
        end
        PH_PAYLOAD: begin
          if (last_byte) phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    kind_nxt    = kind_r;
    idx_nxt     = idx_r;
    payload_nxt = payload_r;
    acc_nxt     = acc_r;
    batt_nxt    = batt_r;
    vis_nxt     = vis_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    ev          = EV_NONE;
    sum         = 32'd0;
    obj_x       = '0;
    obj_y       = '0;
    obj_vis     = 1'b0;
    if (item.op == OP_TAKE) begin
      sum     = acc_r;
      acc_nxt = 32'd0;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          if (item.rx_byte inside {[HDR_ENCODER:HDR_OBJECT]}) begin
            kind_nxt = kind_t'(2'(item.rx_byte - HDR_ENCODER));
            idx_nxt  = 4'd0;
          end
        end
        PH_PAYLOAD: begin
          if (idx_r < 4'(PAYLOAD_LEN)) payload_nxt[idx_r] = item.rx_byte;
          idx_nxt = last_byte ? 4'd0 : idx_inc;
          if (last_byte) begin
            obj_x   = {payload_nxt[4], payload_nxt[3], payload_nxt[2], payload_nxt[1]};
            obj_y   = {payload_nxt[8], payload_nxt[7], payload_nxt[6], payload_nxt[5]};
            obj_vis = !(obj_x[31] && obj_y[31]);
            case (kind_r)
              KIND_ENCODER: begin
                acc_nxt = acc_r + {24'd0, payload_nxt[0]};
                ev      = EV_ENCODER;
              end
              KIND_BATTERY: begin
                batt_nxt = {payload_nxt[1], payload_nxt[0]};
                ev       = EV_BATTERY;
              end
              default: begin
                ev = EV_OBJECT;
                // unknown colour leaves both objects alone
                if (payload_nxt[0] == COL_GREEN || payload_nxt[0] == COL_RED) begin
                  vis_nxt[payload_nxt[0][0]] = obj_vis;
                  if (obj_vis) begin
                    x_nxt[payload_nxt[0][0]] = obj_x;
                    y_nxt[payload_nxt[0][0]] = obj_y;
                  end
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.event_res   = ev;
    res.encoder_sum = sum;
    res.battery_raw = batt_nxt;
    res.green_seen  = vis_nxt[0];
    res.green_x     = x_nxt[0];
    res.green_y     = y_nxt[0];
    res.red_seen    = vis_nxt[1];
    res.red_x       = x_nxt[1];
    res.red_y       = y_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      kind_r  <= KIND_ENCODER;
      idx_r   <= 4'd0;
      acc_r   <= 32'd0;
      batt_r  <= 16'd0;
      vis_r   <= 2'b00;
      x_r     <= '{default: '0};
      y_r     <= '{default: '0};
    end else if (item_vld) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      batt_r  <= batt_nxt;
      vis_r   <= vis_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
    end
  end

  // payload bytes hold no reset value
  always_ff @(posedge clk) begin
    if (item_vld) begin
      payload_r <= payload_nxt;
    end
  end

endmodule

### rtl/core/telemetry_frame_parser_top.sv
// Telemetry frame parser.
// Input channel in_valid/in_ready/in_data carries one request per received
// serial byte (op byte) or a take of the encoder sum (op take).
// Result channel out_valid/out_ready/out_data returns exactly one result per
// request, in order: the event code, the encoder sum on a take, and the
// current battery code and object coordinates after that request.
// cfg_wr_en/cfg_wr_data write the sync byte; write only while idle.
// A request is accepted into the input register and parsed into the result
// register once the result register is empty or being read.
// Throughput: one request per cycle while the receiver does not stall, set
// by the parse logic between the input register and the result register.
// Reset (synchronous, rst_n low): parser hunts for sync, sync byte 0x16,
// encoder sum, battery code and objects cleared, both channels empty.
// When the receiver stalls the result register holds; one more request
// waits in the input register, after which in_ready drops.
module telemetry_frame_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tfp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tfp_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data
);
  import tfp_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  in_t        in_r;
  logic       out_vld_r, out_vld_nxt;
  out_t       out_r;
  out_t       res;
  logic [7:0] sync_r;
  logic       advance;
  logic       accept;

  assign advance     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready    = !in_vld_r || advance;
  assign accept      = in_valid && in_ready;
  assign in_vld_nxt  = accept || (in_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && !out_ready);

  tfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .sync_byte (sync_r),
    .item_vld  (advance),
    .item      (in_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      sync_r    <= SYNC_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) sync_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_r <= in_data;
    if (advance) out_r <= res;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### tb/telemetry_frame_parser_top_test.sv
module telemetry_frame_parser_top_test;
  import tfp_pkg::*;

  localparam logic [7:0] HDR_BATTERY = 8'd3;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    in_t         req;
    logic        pinned;
    event_t      ev;
    logic [31:0] sum;
  } stim_t;

  // pinned rows carry the event and encoder sum the block must report
  localparam stim_t DIRECTED [25] = '{
    '{'{OP_TAKE, 8'h00}, 1'b1, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'h00}, 1'b1, EV_NONE, 32'd0},
    '{'{OP_BYTE, SYNC_RESET}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, HDR_ENCODER}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'hFF}, 1'b1, EV_ENCODER, 32'd0},
    '{'{OP_BYTE, SYNC_RESET}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, HDR_BATTERY}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'hFF}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_TAKE, 8'hFF}, 1'b1, EV_NONE, 32'd255},
    '{'{OP_BYTE, 8'hFF}, 1'b1, EV_BATTERY, 32'd0},
    '{'{OP_BYTE, SYNC_RESET}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, SYNC_RESET}, 1'b1, EV_NONE, 32'd0},
    '{'{OP_BYTE, SYNC_RESET}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, HDR_OBJECT}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, COL_RED}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'h00}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'h00}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'h00}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'h80}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'hFF}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'hFF}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'hFF}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'h7F}, 1'b1, EV_OBJECT, 32'd0},
    '{'{OP_BYTE, SYNC_RESET}, 1'b0, EV_NONE, 32'd0},
    '{'{OP_BYTE, 8'h05}, 1'b1, EV_NONE, 32'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  stim_t       stim_queue [$];
  out_t        telemetry_due [$];
  stim_t       in_stim = '0;
  stim_t       head;
  out_t        next_due;
  int          in_wait = 0;
  int          out_stall = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  bit          mismatch_seen = 1'b0;
  int          stuck_cycles = 0;

  // parser image kept alongside the block
  logic [7:0]  sync_cfg;
  phase_t      phase;
  kind_t       kind;
  logic [3:0]  idx;
  logic [7:0]  frame_bytes [PAYLOAD_LEN];
  logic [31:0] enc_total;
  logic [15:0] battery_code;
  logic        obj_seen [2];
  logic [31:0] obj_x [2];
  logic [31:0] obj_y [2];

  telemetry_frame_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void clear_parser();
    sync_cfg = SYNC_RESET;
    phase = PH_HUNT;
    kind = KIND_ENCODER;
    idx = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    enc_total = '0;
    battery_code = '0;
    for (int s = 0; s < 2; s++) begin
      obj_seen[s] = 1'b0;
      obj_x[s] = '0;
      obj_y[s] = '0;
    end
  endfunction

  function automatic out_t parse_request(in_t req);
    out_t        res;
    logic [31:0] x, y;
    logic        shown;
    int          frame_len_bytes;
    res = '0;
    res.event_res = EV_NONE;
    if (req.op == OP_TAKE) begin
      res.encoder_sum = enc_total;
      enc_total = '0;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (req.rx_byte == sync_cfg) phase = PH_HEADER;
        end
        PH_HEADER: begin
          case (req.rx_byte)
            HDR_ENCODER: begin
              kind = KIND_ENCODER;
              idx = '0;
              phase = PH_PAYLOAD;
            end
            HDR_BATTERY: begin
              kind = KIND_BATTERY;
              idx = '0;
              phase = PH_PAYLOAD;
            end
            HDR_OBJECT: begin
              kind = KIND_OBJECT;
              idx = '0;
              phase = PH_PAYLOAD;
            end
            default: phase = PH_HUNT;
          endcase
        end
        default: begin
          if (idx < PAYLOAD_LEN) frame_bytes[idx] = req.rx_byte;
          idx = idx + 4'd1;
          case (kind)
            KIND_ENCODER: frame_len_bytes = 1;
            KIND_BATTERY: frame_len_bytes = 2;
            default:      frame_len_bytes = PAYLOAD_LEN;
          endcase
          if (idx >= frame_len_bytes) begin
            case (kind)
              KIND_ENCODER: begin
                enc_total = enc_total + {24'd0, frame_bytes[0]};
                res.event_res = EV_ENCODER;
              end
              KIND_BATTERY: begin
                battery_code = {frame_bytes[1], frame_bytes[0]};
                res.event_res = EV_BATTERY;
              end
              default: begin
                x = {frame_bytes[4], frame_bytes[3], frame_bytes[2], frame_bytes[1]};
                y = {frame_bytes[8], frame_bytes[7], frame_bytes[6], frame_bytes[5]};
                // hidden only when both coordinates are negative
                shown = !(x[31] && y[31]);
                if (frame_bytes[0] == COL_GREEN || frame_bytes[0] == COL_RED) begin
                  obj_seen[frame_bytes[0][0]] = shown;
                  if (shown) begin
                    obj_x[frame_bytes[0][0]] = x;
                    obj_y[frame_bytes[0][0]] = y;
                  end
                end
                res.event_res = EV_OBJECT;
              end
            endcase
            phase = PH_HUNT;
            idx = '0;
          end
        end
      endcase
    end
    res.battery_raw = battery_code;
    res.green_seen = obj_seen[0];
    res.green_x = obj_x[0];
    res.green_y = obj_y[0];
    res.red_seen = obj_seen[1];
    res.red_x = obj_x[1];
    res.red_y = obj_y[1];
    return res;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  function automatic void check_telemetry(out_t got);
    out_t want;
    if (telemetry_due.size() == 0) begin
      $error("result with no request outstanding");
      mismatch_seen = 1'b1;
    end else begin
      want = telemetry_due.pop_front();
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("encoder_sum", want.encoder_sum, got.encoder_sum);
      compare_field("battery_raw", want.battery_raw, got.battery_raw);
      compare_field("green_seen", want.green_seen, got.green_seen);
      compare_field("green_x", want.green_x, got.green_x);
      compare_field("green_y", want.green_y, got.green_y);
      compare_field("red_seen", want.red_seen, got.red_seen);
      compare_field("red_x", want.red_x, got.red_x);
      compare_field("red_y", want.red_y, got.red_y);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait <= 0;
      clear_parser();
    end else begin
      if (cfg_wr_en) sync_cfg = cfg_wr_data;
      if (in_valid && in_ready) begin
        next_due = parse_request(in_data);
        if (in_stim.pinned) begin
          next_due.event_res = in_stim.ev;
          next_due.encoder_sum = in_stim.sum;
        end
        telemetry_due.push_back(next_due);
      end
      if (!in_valid || in_ready) begin
        if (in_wait != 0) begin
          in_valid <= 1'b0;
          in_wait <= in_wait - 1;
        end else if (stim_queue.size() != 0) begin
          head = stim_queue.pop_front();
          in_stim <= head;
          in_data <= head.req;
          in_valid <= 1'b1;
          in_wait <= in_calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if ($urandom_range(127) == 0) in_calm <= !in_calm;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) check_telemetry(out_data);
      if (out_stall != 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (!out_calm && $urandom_range(99) < 25) begin
        out_ready <= 1'b0;
        out_stall <= pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
      if ($urandom_range(127) == 0) out_calm <= !out_calm;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic push_request(input logic op, input logic [7:0] b);
    stim_t s;
    s = '0;
    s.req.op = op;
    s.req.rx_byte = b;
    s.ev = EV_NONE;
    stim_queue.push_back(s);
  endtask

  task automatic queue_frame(input logic [7:0] sync);
    logic [7:0]  seq [$];
    logic [31:0] x, y;
    int          pick, take_at;
    pick = $urandom_range(99);
    take_at = -1;
    if (pick < 64) begin
      seq.push_back(sync);
      case ($urandom_range(2))
        0: begin
          seq.push_back(HDR_ENCODER);
          seq.push_back(8'($urandom));
        end
        1: begin
          seq.push_back(HDR_BATTERY);
          seq.push_back(8'($urandom));
          seq.push_back(8'($urandom));
        end
        default: begin
          seq.push_back(HDR_OBJECT);
          pick = $urandom_range(9);
          seq.push_back(pick < 4 ? COL_GREEN : pick < 8 ? COL_RED : 8'($urandom));
          x = pick_coord();
          y = pick_coord();
          for (int k = 0; k < 4; k++) seq.push_back(x[8*k +: 8]);
          for (int k = 0; k < 4; k++) seq.push_back(y[8*k +: 8]);
        end
      endcase
      // take request landing inside a frame
      if ($urandom_range(9) == 0) take_at = $urandom_range(seq.size() - 1, 1);
    end else if (pick < 74) begin
      push_request(OP_TAKE, 8'($urandom));
    end else if (pick < 86) begin
      seq.push_back(8'($urandom));
    end else if (pick < 94) begin
      seq.push_back(sync);
      seq.push_back($urandom_range(3) == 0 ? sync : 8'($urandom));
    end else begin
      // truncated object frame, the next bytes finish it
      seq.push_back(sync);
      seq.push_back(HDR_OBJECT);
      repeat ($urandom_range(8, 1)) seq.push_back(8'($urandom));
    end
    foreach (seq[i]) begin
      if (i == take_at) push_request(OP_TAKE, 8'($urandom));
      push_request(OP_BYTE, seq[i]);
    end
  endtask

  task automatic queue_traffic(input logic [7:0] sync, input int count);
    int goal;
    goal = stim_queue.size() + count;
    while (stim_queue.size() < goal) queue_frame(sync);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (stim_queue.size() != 0 || in_valid || telemetry_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] sync_pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) stim_queue.push_back(DIRECTED[i]);
    queue_traffic(SYNC_RESET, 110);
    wait_idle();
    write_sync(8'h00);
    queue_traffic(8'h00, 130);
    wait_idle();
    write_sync(8'hFF);
    queue_traffic(8'hFF, 130);
    wait_idle();
    sync_pick = 8'($urandom);
    write_sync(sync_pick);
    queue_traffic(sync_pick, 130);
    wait_idle();
    write_sync(SYNC_RESET);
    queue_traffic(SYNC_RESET, 30);
    wait_idle();
    repeat (8) @(posedge clk);
    if (!mismatch_seen) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tfp_pkg.sv
rtl/core/tfp_parser.sv
rtl/core/telemetry_frame_parser_top.sv
tb/telemetry_frame_parser_top_test.sv
